// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/pcrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Parametric CRC package
// Request types, command codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package pcrc_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned MAX_WIDTH_DEF = 64;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XOROUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFOUT   = 3'd5;

  // Reset values: the common 32-bit Ethernet CRC.
  localparam logic [6:0]        WIDTH_RST  = 7'd32;
  localparam logic [DATA_W-1:0] POLY_RST   = 64'h0000_0000_04C1_1DB7;
  localparam logic [DATA_W-1:0] INIT_RST   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0] XOROUT_RST = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } pcrc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] crc_value;
    logic [DATA_W-1:0] residue_value;
  } pcrc_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } pcrc_cfg_t;

endpackage

// ===== rtl/pcrc_chan_if.sv =====
// ---------------------------------------------------------------------------
// Parametric CRC channel
// Valid/ready channel with a payload of selectable type.
// ---------------------------------------------------------------------------
interface pcrc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/parametric_crc_engine_core.sv =====
// ---------------------------------------------------------------------------
// Parametric CRC engine core
// A finish request's result is registered in the output register, or in the
// skid entry while the output stalls; start and data requests update the CRC
// register on acceptance. One request per cycle, with the eight shift steps
// unrolled, while setup is done and the skid entry is free. Reset, and every
// configuration write, start a setup pass (a prep state, then residue steps) during which no request is accepted.
// The CRC register resets to zero; configuration resets to the 32-bit CRC.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module parametric_crc_engine_core #(
  parameter int unsigned MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  pcrc_chan_if.sink   in_if,
  pcrc_chan_if.source out_if,
  pcrc_chan_if.sink   cfg_if
);
  import pcrc_pkg::*;

  localparam int unsigned MW = MAX_WIDTH;
  localparam int unsigned WW = $clog2(MW + 1);  // holds a width up to MW
  localparam int unsigned SW = $clog2(MW);      // holds MW minus a width

  // Setup sequencer codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  // Reverse the low bits of v within the effective width: a full reversal
  // followed by a right shift that drops the bits above the width.
  function automatic logic [MW-1:0] mirror_w(input logic [MW-1:0] v,
                                             input logic [SW-1:0] sh);
    logic [MW-1:0] r;
    for (int i = 0; i < MW; i++) begin
      r[i] = v[MW-1-i];
    end
    return r >> sh;
  endfunction

  function automatic logic [MW-1:0] shift_once(input logic [MW-1:0] r,
                                               input logic [MW-1:0] p);
    return r[0] ? ((r >> 1) ^ p) : (r >> 1);
  endfunction

  // -------------------------------------------------------------------------
  // Configuration registers. Only the low MW bits of the wide values can
  // ever matter, since every value is masked to the width before use.
  // -------------------------------------------------------------------------
  logic [6:0]    cw_q;
  logic [MW-1:0] poly_q, init_q, xorout_q;
  logic          refin_q, refout_q;
  logic          cfg_fire;

  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q     <= WIDTH_RST;
      poly_q   <= MW'(POLY_RST);
      init_q   <= MW'(INIT_RST);
      xorout_q <= MW'(XOROUT_RST);
      refin_q  <= 1'b1;
      refout_q <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_if.payload.index)
        REG_WIDTH:  cw_q     <= cfg_if.payload.data[6:0];
        REG_POLY:   poly_q   <= cfg_if.payload.data[MW-1:0];
        REG_INIT:   init_q   <= cfg_if.payload.data[MW-1:0];
        REG_XOROUT: xorout_q <= cfg_if.payload.data[MW-1:0];
        REG_REFIN:  refin_q  <= cfg_if.payload.data[0];
        REG_REFOUT: refout_q <= cfg_if.payload.data[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Setup pass. The reflected polynomial, init and final XOR, the width mask
  // and the check residue depend on configuration alone, so they are derived
  // once after reset or a write. The residue needs w dependent shift steps;
  // it runs eight steps a cycle in the residue state until none are left.
  // -------------------------------------------------------------------------
  logic [1:0]    state_q, state_d;
  logic [WW-1:0] cnt_q, cnt_d;
  logic [MW-1:0] mask_q, rpoly_q, rinit_q, rxor_q, res_q, resid_q;
  logic [SW-1:0] shamt_q;

  logic [6:0]    w7;
  logic [WW-1:0] weff, wdiff;
  logic [SW-1:0] shamt_c;
  logic [MW-1:0] mask_c, res_c;

  always_comb begin
    // A width of zero acts as one, and one above MW acts as MW.
    if (cw_q == 7'd0) begin
      w7 = 7'd1;
    end else if (cw_q > 7'(MW)) begin
      w7 = 7'(MW);
    end else begin
      w7 = cw_q;
    end
    weff    = WW'(w7);
    wdiff   = WW'(MW) - weff;
    shamt_c = wdiff[SW-1:0];
    mask_c  = {MW{1'b1}} >> shamt_c;
  end

  always_comb begin
    res_c = res_q;
    for (int k = 0; k < 8; k++) begin
      if (WW'(k) < cnt_q) begin
        res_c = shift_once(res_c, rpoly_q);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (cfg_fire) begin
      state_d = ST_PREP;
    end else begin
      unique case (state_q)
        ST_PREP: begin
          state_d = ST_RES;
          cnt_d   = weff;
        end
        ST_RES: begin
          if (cnt_q <= WW'(8)) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d   = cnt_q - WW'(8);
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cfg_fire && state_q == ST_PREP) begin
      mask_q  <= mask_c;
      shamt_q <= shamt_c;
      rpoly_q <= mirror_w(poly_q & mask_c, shamt_c);
      rinit_q <= mirror_w(init_q & mask_c, shamt_c);
      rxor_q  <= mirror_w(xorout_q & mask_c, shamt_c);
      res_q   <= mirror_w(xorout_q & mask_c, shamt_c);
    end else if (!cfg_fire && state_q == ST_RES) begin
      res_q <= res_c;
      if (cnt_q <= WW'(8)) begin
        resid_q <= refout_q ? res_c : mirror_w(res_c, shamt_q);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Request path. The CRC register is masked to the current width before
  // use, so a width change between messages or mid-message behaves as the
  // register would if it had been truncated.
  // -------------------------------------------------------------------------
  logic [MW-1:0] crc_q, crc_d, reg_m, reg_x, crc_fin;
  logic [7:0]    byte_in;
  logic          in_fire, gen;
  logic          out_valid_q, skid_valid_q, out_fire;
  pcrc_out_t     out_q, skid_q, new_res;

  // A request is taken whenever setup is done and the skid slot is free, so
  // a request can follow a finish whose result is still waiting.
  assign in_if.ready = (state_q == ST_IDLE) && !skid_valid_q;
  assign in_fire     = in_if.valid && in_if.ready;
  assign gen         = in_fire && (in_if.payload.func == FUNC_FINISH);
  assign out_fire    = out_valid_q && out_if.ready;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_in[i] = refin_q ? in_if.payload.data_byte[i] : in_if.payload.data_byte[7-i];
    end
  end

  always_comb begin
    reg_m = crc_q & mask_q;
    reg_x = reg_m ^ MW'(byte_in);
    for (int k = 0; k < 8; k++) begin
      reg_x = shift_once(reg_x, rpoly_q);
    end
    crc_fin = refout_q ? (reg_m ^ rxor_q) : mirror_w(reg_m ^ rxor_q, shamt_q);
    new_res.crc_value     = DATA_W'(crc_fin);
    new_res.residue_value = DATA_W'(resid_q);
  end

  always_comb begin
    crc_d = crc_q;
    if (in_fire) begin
      unique case (in_if.payload.func)
        FUNC_START:  crc_d = rinit_q;
        FUNC_DATA:   crc_d = reg_x & mask_q;
        FUNC_FINISH: crc_d = rinit_q;
        default:     crc_d = crc_q;  // unused code: no effect
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  // Output register with one skid entry; the output register always holds
  // the older of the two results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= gen;
      end else begin
        out_valid_q  <= gen;
      end
    end else if (gen) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (gen) begin
          skid_q <= new_res;
        end
      end else if (gen) begin
        out_q <= new_res;
      end
    end else if (gen) begin
      skid_q <= new_res;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_AT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid entry without an output entry")
  `ASSERT_AT(a_stall_to_skid, clk_i, rst_ni, (gen && out_valid_q && !out_if.ready) |=> skid_valid_q, "stalled finish result was lost")
  `ASSERT_AT(a_prep_loads_count, clk_i, rst_ni, (state_q == ST_PREP && !cfg_fire) |=> (state_q == ST_RES && cnt_q != '0), "setup pass started with no residue steps")
  `ASSERT_NEVER(a_no_request_in_setup, clk_i, rst_ni, in_fire && (state_q != ST_IDLE), "request taken during the setup pass")

endmodule
